// ===== src/mmu_pkg.sv =====
package mmu_pkg;

  localparam int DIM_DEF  = 4;
  localparam int FRAC_DEF = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int FUNC_W   = 2;
  localparam int PROD_W   = 2 * DATA_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_L    = 2'd0,
    FN_LOAD_R    = 2'd1,
    FN_MUL       = 2'd2,
    FN_MUL_STORE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_WB
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic rd;
    logic first;
    logic last;
    logic post;
  } mac_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] value;
    logic              sat;
  } mac_res_t;

endpackage

// ===== src/mmu_store.sv =====
module mmu_store
  import mmu_pkg::*;
#(
  parameter int DEPTH  = DIM_DEF * DIM_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mmu_mac.sv =====
module mmu_mac
  import mmu_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] ldata,
  input  logic signed [DATA_W-1:0] rdata,
  output mac_res_t                 res
);

  localparam int ACC_W = PROD_W + $clog2(DIM);

  logic                    rd_d_r, first_d_r, last_d_r;
  logic                    pv_r, pfirst_r, plast_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                    sum_vld_r;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    hi_bits;
  logic                    ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_d_r    <= 1'b0;
      pv_r      <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      rd_d_r <= ctl.rd;
      pv_r   <= rd_d_r;
      if (pv_r && plast_r) begin
        sum_vld_r <= 1'b1;
      end else if (ctl.post) begin
        sum_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_d_r <= ctl.first;
    last_d_r  <= ctl.last;
    pfirst_r  <= first_d_r;
    plast_r   <= last_d_r;
    prod_r    <= PROD_W'(ldata) * PROD_W'(rdata);
    if (pv_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    acc_nxt = (pfirst_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
  end

  // floor shift, then clip to 32 bits
  always_comb begin
    shifted   = acc_r >>> FRAC_BITS;
    hi_bits   = shifted[ACC_W-1:DATA_W-1];
    ovf       = !((&hi_bits) || !(|hi_bits));
    res.vld   = sum_vld_r;
    res.sat   = ovf;
    if (!ovf) begin
      res.value = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res.value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

// ===== src/mmu_ctrl.sv =====
module mmu_ctrl
  import mmu_pkg::*;
#(
  parameter int DIM    = DIM_DEF,
  parameter int CELLS  = DIM * DIM,
  parameter int ADDR_W = $clog2(CELLS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [IDX_W-1:0]         in_element_index,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_saturated,
  output logic                     out_last,
  input  mac_res_t                 res,
  output mac_ctl_t                 ctl,
  output logic                     l_we,
  output logic [ADDR_W-1:0]        l_waddr,
  output logic [DATA_W-1:0]        l_wdata,
  output logic [ADDR_W-1:0]        l_raddr,
  output logic                     r_we,
  output logic [ADDR_W-1:0]        r_waddr,
  output logic [DATA_W-1:0]        r_wdata,
  output logic [ADDR_W-1:0]        r_raddr
);

  localparam int DIM_W = $clog2(DIM);

  state_t              state_r, state_nxt;
  logic [DIM_W-1:0]    i_r, j_r, k_r;
  logic [ADDR_W-1:0]   pos_r;
  logic                store_r;
  logic [DATA_W-1:0]   rowbuf [DIM];
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [DATA_W-1:0]   out_value_r;
  logic                out_sat_r, out_last_r;

  func_t               func;
  logic                accept, is_mul, load_ok;
  logic                i_last, j_last, k_last, post;
  logic [ADDR_W-1:0]   row_base;

  always_comb begin
    func     = func_t'(in_func);
    accept   = in_valid && (state_r == ST_IDLE);
    is_mul   = (func == FN_MUL) || (func == FN_MUL_STORE);
    load_ok  = accept && !is_mul && (32'(in_element_index) < CELLS);
    i_last   = (i_r == DIM_W'(DIM - 1));
    j_last   = (j_r == DIM_W'(DIM - 1));
    k_last   = (k_r == DIM_W'(DIM - 1));
    row_base = ADDR_W'(i_r) * ADDR_W'(DIM);
    post     = (state_r == ST_WAIT) && res.vld && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_mul) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (k_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (post) begin
          if (!j_last)      state_nxt = ST_ISSUE;
          else if (store_r) state_nxt = ST_WB;
          else if (i_last)  state_nxt = ST_IDLE;
          else              state_nxt = ST_ISSUE;
        end
      end
      ST_WB: begin
        if (k_last) state_nxt = i_last ? ST_IDLE : ST_ISSUE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    ctl.rd    = (state_r == ST_ISSUE);
    ctl.first = (k_r == '0);
    ctl.last  = k_last;
    ctl.post  = post;
    l_raddr   = row_base + ADDR_W'(k_r);
    r_raddr   = ADDR_W'(k_r) * ADDR_W'(DIM) + ADDR_W'(j_r);
    if (state_r == ST_WB) begin
      l_we    = 1'b1;
      l_waddr = row_base + ADDR_W'(k_r);
      l_wdata = rowbuf[k_r];
    end else begin
      l_we    = load_ok && (func == FN_LOAD_L);
      l_waddr = ADDR_W'(in_element_index);
      l_wdata = in_element_value;
    end
    r_we    = load_ok && (func == FN_LOAD_R);
    r_waddr = ADDR_W'(in_element_index);
    r_wdata = in_element_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      pos_r       <= '0;
      store_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && is_mul) begin
        i_r     <= '0;
        j_r     <= '0;
        k_r     <= '0;
        pos_r   <= '0;
        store_r <= (func == FN_MUL_STORE);
      end
      if (state_r == ST_ISSUE || state_r == ST_WB) begin
        k_r <= k_last ? '0 : k_r + 1'b1;
      end
      if (state_r == ST_WB && k_last) begin
        i_r <= i_r + 1'b1;
      end
      if (post) begin
        pos_r <= pos_r + 1'b1;
        if (j_last) begin
          j_r <= '0;
          if (!store_r) i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      rowbuf[j_r] <= res.value;
      out_index_r <= IDX_W'(pos_r);
      out_value_r <= res.value;
      out_sat_r   <= res.sat;
      out_last_r  <= (pos_r == ADDR_W'(CELLS - 1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

endmodule

// ===== src/matrix_multiply_4x4_unit.sv =====
// DIM x DIM fixed-point (signed Q16.16) matrix multiplier.
// Input channel (in_valid / in_stall): each word carries in_func,
// in_element_index and in_element_value. Load-left and load-right words
// write one element of the left or right store and are taken one per cycle;
// an index beyond the matrix is dropped. A multiply word (with or without
// write-back into the left store) streams DIM*DIM product elements in
// row-major order on the result channel (out_valid / out_stall), each with
// its index, a saturation flag and a last flag on the final element.
// For each product element, DIM reads of both stores feed one 32x32
// multiplier and an accumulator through the read, multiply and accumulate
// registers. After each row, the write-back variant copies the buffered
// row into the left store. in_stall stays high until the whole product
// is out of the sequencer.
// A stalled receiver holds the result register; the sequencer waits and
// the accumulator keeps its sum until the register frees up.
// Reset clears the sequencer and the result valid; store contents are
// undefined until loaded.
module matrix_multiply_4x4_unit
  import mmu_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [IDX_W-1:0]         in_element_index,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_saturated,
  output logic                     out_last
);

  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(CELLS);

  mac_ctl_t          ctl;
  mac_res_t          res;
  logic              l_we, r_we;
  logic [ADDR_W-1:0] l_waddr, l_raddr, r_waddr, r_raddr;
  logic [DATA_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

  mmu_ctrl #(
    .DIM    (DIM),
    .CELLS  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_saturated    (out_saturated),
    .out_last         (out_last),
    .res              (res),
    .ctl              (ctl),
    .l_we             (l_we),
    .l_waddr          (l_waddr),
    .l_wdata          (l_wdata),
    .l_raddr          (l_raddr),
    .r_we             (r_we),
    .r_waddr          (r_waddr),
    .r_wdata          (r_wdata),
    .r_raddr          (r_raddr)
  );

  mmu_store #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_left (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (ctl.rd),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  mmu_store #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_right (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (ctl.rd),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  mmu_mac #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ldata (l_rdata),
    .rdata (r_rdata),
    .res   (res)
  );

endmodule

// ===== tb/sv/tb_matrix_multiply_4x4_unit.sv =====
module tb_matrix_multiply_4x4_unit
  import mmu_pkg::*;
();

  localparam int CELLS = DIM_DEF * DIM_DEF;
  localparam int LIMIT = 1_000_000;
  localparam int N_WORDS = 350;
  localparam logic [DATA_W-1:0] ONE_Q = 32'h0001_0000;
  localparam logic [DATA_W-1:0] MAX_Q = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_Q = 32'h8000_0000;

  class product_scoreboard;
    typedef struct {
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] value;
      logic              sat;
      logic              last;
    } elem_t;

    logic [DATA_W-1:0] left_q [CELLS];
    logic [DATA_W-1:0] right_q[CELLS];
    elem_t             expected_elems[$];
    int                errors;

    function new();
      errors = 0;
      foreach (left_q[n]) begin
        left_q[n]  = '0;
        right_q[n] = '0;
      end
    endfunction

    // loads update the stores; multiplies queue DIM*DIM product elements
    function void note_word(func_t f, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      logic signed [67:0] acc;
      logic signed [67:0] a;
      logic signed [67:0] b;
      logic signed [67:0] shifted;
      logic [DATA_W-1:0]  prod[CELLS];
      elem_t              e;
      int                 pos;
      case (f)
        FN_LOAD_L: begin
          if (idx < CELLS) left_q[idx] = val;
        end
        FN_LOAD_R: begin
          if (idx < CELLS) right_q[idx] = val;
        end
        default: begin
          for (int i = 0; i < DIM_DEF; i++) begin
            for (int j = 0; j < DIM_DEF; j++) begin
              acc = '0;
              for (int k = 0; k < DIM_DEF; k++) begin
                a = $signed(left_q[i*DIM_DEF+k]);
                b = $signed(right_q[k*DIM_DEF+j]);
                acc = acc + a * b;
              end
              shifted = acc >>> FRAC_DEF;
              pos = i * DIM_DEF + j;
              e.idx = pos[IDX_W-1:0];
              if (shifted > $signed({36'd0, MAX_Q})) begin
                e.value = MAX_Q;
                e.sat   = 1'b1;
              end else if (shifted < $signed({36'hF_FFFF_FFFF, MIN_Q})) begin
                e.value = MIN_Q;
                e.sat   = 1'b1;
              end else begin
                e.value = shifted[DATA_W-1:0];
                e.sat   = 1'b0;
              end
              e.last = (pos == CELLS - 1);
              prod[pos] = e.value;
              expected_elems.push_back(e);
            end
          end
          if (f == FN_MUL_STORE) left_q = prod;
        end
      endcase
    endfunction

    function void check_elem(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                             logic sat, logic last);
      elem_t e;
      if (expected_elems.size() == 0) begin
        $display("%0t: unexpected word idx=%0d value=%h", $time, idx, val);
        errors++;
        return;
      end
      e = expected_elems.pop_front();
      if (idx !== e.idx) begin
        $display("%0t: index exp %0d got %0d", $time, e.idx, idx);
        errors++;
      end
      if (val !== e.value) begin
        $display("%0t: value idx %0d exp %h got %h", $time, e.idx, e.value, val);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated idx %0d exp %b got %b", $time, e.idx, e.sat, sat);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last idx %0d exp %b got %b", $time, e.idx, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [FUNC_W-1:0]        in_func;
  logic [IDX_W-1:0]         in_element_index;
  logic signed [DATA_W-1:0] in_element_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [IDX_W-1:0]         out_index;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_saturated;
  logic                     out_last;

  product_scoreboard sb;
  int                words_sent;
  int                cycles;
  logic              no_idle;

  matrix_multiply_4x4_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_saturated    (out_saturated),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_cycles();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] rand_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 2**19) - 2**18;
    if (r < 80) return $urandom;
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0: return MAX_Q;
        1: return MIN_Q;
        2: return ONE_Q;
        default: return '0;
      endcase
    end
    return $urandom_range(0, 16) - 8;
  endfunction

  task automatic send_word(func_t f, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_element_index <= idx;
    in_element_value <= val;
    do @(posedge clk); while (in_stall);
    sb.note_word(f, idx, val);
    words_sent++;
  endtask

  task automatic wait_products_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_elems.size() != 0);
  endtask

  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = gap_cycles();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_elem(out_index, out_value, out_saturated, out_last);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int r;
    int n;
    sb               = new();
    words_sent       = 0;
    cycles           = 0;
    no_idle          = 1'b0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_func          <= FN_LOAD_L;
    in_element_index <= '0;
    in_element_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // identity times random
    for (int i = 0; i < CELLS; i++)
      send_word(FN_LOAD_L, IDX_W'(i), (i / DIM_DEF == i % DIM_DEF) ? ONE_Q : '0);
    for (int i = 0; i < CELLS; i++)
      send_word(FN_LOAD_R, IDX_W'(i), rand_elem());
    send_word(FN_MUL, '0, '0);

    // positive and negative saturation
    for (int k = 0; k < DIM_DEF; k++) begin
      send_word(FN_LOAD_L, IDX_W'(k), MAX_Q);
      send_word(FN_LOAD_R, IDX_W'(k * DIM_DEF), MAX_Q);
      send_word(FN_LOAD_R, IDX_W'(k * DIM_DEF + 1), MIN_Q);
    end
    send_word(FN_MUL_STORE, '0, '0);
    send_word(FN_MUL, '0, '0);
    wait_products_drained();

    // floor of a negative sum
    send_word(FN_LOAD_L, IDX_W'(0), 32'hFFFF_FFFF);
    send_word(FN_LOAD_L, IDX_W'(1), '0);
    send_word(FN_LOAD_L, IDX_W'(2), '0);
    send_word(FN_LOAD_L, IDX_W'(3), '0);
    send_word(FN_LOAD_R, IDX_W'(0), 32'h0000_0001);
    send_word(FN_LOAD_R, IDX_W'(15), MIN_Q);
    send_word(FN_MUL, '0, '0);

    while (words_sent < N_WORDS) begin
      if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_word($urandom_range(0, 1) ? FN_LOAD_R : FN_LOAD_L,
                    IDX_W'($urandom_range(0, CELLS - 1)), rand_elem());
        send_word($urandom_range(0, 1) ? FN_MUL_STORE : FN_MUL,
                  IDX_W'($urandom_range(0, 15)), $urandom);
      end else if (r < 80) begin
        send_word(func_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 15)), $urandom);
      end else if (r < 95) begin
        n = $urandom_range(4, 12);
        repeat (n)
          send_word($urandom_range(0, 1) ? FN_LOAD_R : FN_LOAD_L,
                    IDX_W'($urandom_range(0, 15)), $urandom);
      end else begin
        wait_products_drained();
      end
    end

    wait_products_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_elems.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mmu_pkg.sv
src/mmu_store.sv
src/mmu_mac.sv
src/mmu_ctrl.sv
src/matrix_multiply_4x4_unit.sv
tb/sv/tb_matrix_multiply_4x4_unit.sv
